// ----- design/rfcs_pkg.sv -----
// Shared constants, opcodes and table entry type for the receive flow CPU steering block.
// No dependencies.
package rfcs_pkg;

	localparam int MAX_FLOWS = 128;
	localparam int MAX_CPUS  = 64;

	localparam int FID_W     = 32;
	localparam int CPU_W     = 6;
	localparam int CNT_W     = 16;
	localparam int OP_W      = 2;
	localparam int ENT_CFG_W = 8;
	localparam int CPU_CFG_W = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 8;

	localparam int IDX_W  = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
	localparam int DIVA_W = $clog2(MAX_FLOWS + 1);
	localparam int DIVB_W = $clog2(MAX_CPUS + 1);

	localparam int DIV_STEPS = 4;
	localparam int DIV_CYC   = FID_W / DIV_STEPS;
	localparam int DCNT_W    = $clog2(DIV_CYC + 1);

	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [OP_W-1:0] OP_RECORD = 2'd1;
	localparam logic [OP_W-1:0] OP_DONE   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FLOW_ENTRIES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CPU_COUNT    = 2'd1;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	typedef struct packed {
		logic             cons_vld;
		logic [CPU_W-1:0] cons_cpu;
		logic [CPU_W-1:0] steer;
		logic [CNT_W-1:0] cnt;
	} entry_t;

	typedef struct packed {
		logic              done;
		logic [DIVA_W-1:0] rem_a;
		logic [DIVB_W-1:0] rem_b;
	} rem_res_t;

endpackage

// ----- design/rfcs_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// No dependencies.
module rfcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/rfcs_rem.sv -----
// Iterative remainder unit: flow id modulo two divisors at once, DIV_STEPS bits per cycle.
// Depends on rfcs_pkg.
module rfcs_rem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rfcs_pkg::FID_W-1:0]  dividend,
	input  logic [rfcs_pkg::DIVA_W-1:0] div_a,
	input  logic [rfcs_pkg::DIVB_W-1:0] div_b,
	output rfcs_pkg::rem_res_t          res
);
	import rfcs_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [FID_W-1:0]  quo_q;
	logic [DIVA_W-1:0] da_q;
	logic [DIVB_W-1:0] db_q;
	logic [DIVA_W-1:0] ra_q;
	logic [DIVB_W-1:0] rb_q;
	logic [DIVA_W-1:0] ra_n;
	logic [DIVB_W-1:0] rb_n;

	always_comb begin
		logic [DIVA_W:0] ta;
		logic [DIVB_W:0] tb;
		ra_n = ra_q;
		rb_n = rb_q;
		for (int k = 0; k < DIV_STEPS; k++) begin
			ta = {ra_n, quo_q[FID_W-1-k]};
			if (ta >= {1'b0, da_q}) begin
				ta = ta - {1'b0, da_q};
			end
			ra_n = ta[DIVA_W-1:0];
			tb = {rb_n, quo_q[FID_W-1-k]};
			if (tb >= {1'b0, db_q}) begin
				tb = tb - {1'b0, db_q};
			end
			rb_n = tb[DIVB_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DIV_CYC);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			da_q  <= div_a;
			db_q  <= div_b;
			ra_q  <= '0;
			rb_q  <= '0;
		end else if (busy_q) begin
			quo_q <= quo_q << DIV_STEPS;
			ra_q  <= ra_n;
			rb_q  <= rb_n;
		end
	end

	assign res.done  = done_q;
	assign res.rem_a = ra_q;
	assign res.rem_b = rb_q;

endmodule

// ----- design/receive_flow_cpu_steering.sv -----
// Top level of the receive flow CPU steering block: control sequencer, table RAM, config.
// Depends on rfcs_pkg, rfcs_ram and rfcs_rem.

// One item at a time: an accepted beat passes through the iterative remainder unit, which
// forms flow id mod flow_entries and mod cpu_count (zero taken as one, capped at MAX_FLOWS
// and MAX_CPUS), followed by one table read and, where the operation writes, one write back.
// The result sits in an output register, so the next beat is taken while it waits; a lookup
// whose result finds that register still full holds in the write-back cycle. Entries read as
// zero with no consumer recorded until first written, tracked by a per-entry valid bit, so no
// clearing pass is needed after reset. Configuration writes are always accepted.
module receive_flow_cpu_steering (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic [rfcs_pkg::OP_W-1:0]      opcode,
	input  logic [rfcs_pkg::FID_W-1:0]     flow_id,
	input  logic [rfcs_pkg::CPU_W-1:0]     cpu_number,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [rfcs_pkg::CPU_W-1:0]     target_cpu,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rfcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rfcs_pkg::CFG_W-1:0]     cfg_data
);
	import rfcs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_RMW  = 3'b100
	} state_t;

	state_t               state_q;
	logic [ENT_CFG_W-1:0] flow_entries_q;
	logic [CPU_CFG_W-1:0] cpu_count_q;
	logic [OP_W-1:0]      op_q;
	logic [FID_W-1:0]     fid_q;
	logic [CPU_W-1:0]     cpu_q;
	logic [IDX_W-1:0]     idx_q;
	logic [CPU_W-1:0]     def_q;
	logic                 vld_q [MAX_FLOWS];
	logic                 res_vld_q;
	logic [CPU_W-1:0]     res_cpu_q;

	logic [DIVA_W-1:0] eff_ent;
	logic [DIVB_W-1:0] eff_cpu;
	logic              accept;
	logic              rem_start;
	rem_res_t          rem;
	logic [IDX_W-1:0]  rem_idx;

	logic [$bits(entry_t)-1:0] ram_rdata;
	logic                      ram_re;
	logic                      ram_we;
	entry_t                    ent;
	entry_t                    ent_new;
	logic [CPU_W-1:0]          tgt;
	logic                      wr;
	logic                      stall;
	logic                      res_load;

	assign cfg_ready  = 1'b1;
	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign rem_start  = accept;
	assign rem_idx    = rem.rem_a[IDX_W-1:0];

	always_comb begin
		if (flow_entries_q == '0) begin
			eff_ent = DIVA_W'(1);
		end else if (32'(flow_entries_q) > 32'(MAX_FLOWS)) begin
			eff_ent = DIVA_W'(MAX_FLOWS);
		end else begin
			eff_ent = DIVA_W'(flow_entries_q);
		end
		if (cpu_count_q == '0) begin
			eff_cpu = DIVB_W'(1);
		end else if (32'(cpu_count_q) > 32'(MAX_CPUS)) begin
			eff_cpu = DIVB_W'(MAX_CPUS);
		end else begin
			eff_cpu = DIVB_W'(cpu_count_q);
		end
	end

	rfcs_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (flow_id),
		.div_a    (eff_ent),
		.div_b    (eff_cpu),
		.res      (rem)
	);

	assign ram_re = (state_q == S_DIV) && rem.done;

	rfcs_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_FLOWS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (ent_new),
		.re    (ram_re),
		.raddr (rem_idx),
		.rdata (ram_rdata)
	);

	always_comb begin
		ent     = vld_q[idx_q] ? entry_t'(ram_rdata) : '0;
		ent_new = ent;
		tgt     = ent.cons_cpu;
		wr      = 1'b0;
		unique case (op_q)
			OP_LOOKUP: begin
				if (!ent.cons_vld) begin
					tgt         = def_q;
					ent_new.steer = def_q;
				end else if (ent.cons_cpu != ent.steer) begin
					if (ent.cnt == '0) begin
						ent_new.steer = ent.cons_cpu;
					end else begin
						tgt = ent.steer;
					end
				end
				if (ent.cnt != COUNT_MAX) begin
					ent_new.cnt = ent.cnt + 1'b1;
				end
				wr = 1'b1;
			end
			OP_RECORD: begin
				if (fid_q != '0) begin
					ent_new.cons_vld = 1'b1;
					ent_new.cons_cpu = cpu_q;
					wr               = 1'b1;
				end
			end
			OP_DONE: begin
				if (ent.cnt != '0) begin
					ent_new.cnt = ent.cnt - 1'b1;
				end
				wr = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign stall    = (op_q == OP_LOOKUP) && res_vld_q && !result_ready;
	assign ram_we   = (state_q == S_RMW) && !stall && wr;
	assign res_load = (state_q == S_RMW) && !stall && (op_q == OP_LOOKUP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			flow_entries_q <= ENT_CFG_W'(128);
			cpu_count_q    <= CPU_CFG_W'(1);
			res_vld_q      <= 1'b0;
			for (int i = 0; i < MAX_FLOWS; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_FLOW_ENTRIES: flow_entries_q <= cfg_data[ENT_CFG_W-1:0];
					REG_CPU_COUNT:    cpu_count_q    <= cfg_data[CPU_CFG_W-1:0];
					default: begin
					end
				endcase
			end
			if (res_load) begin
				res_vld_q <= 1'b1;
			end else if (result_valid && result_ready) begin
				res_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (rem.done) begin
						state_q <= (op_q == OP_LOOKUP || op_q == OP_RECORD || op_q == OP_DONE)
							? S_RMW : S_IDLE;
					end
				end
				S_RMW: begin
					if (!stall) begin
						state_q <= S_IDLE;
						if (wr) begin
							vld_q[idx_q] <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode;
			fid_q <= flow_id;
			cpu_q <= cpu_number;
		end
		if (state_q == S_DIV && rem.done) begin
			idx_q <= rem_idx;
			def_q <= rem.rem_b[CPU_W-1:0];
		end
		if (res_load) begin
			res_cpu_q <= tgt;
		end
	end

	assign result_valid = res_vld_q;
	assign target_cpu   = res_cpu_q;

endmodule
